>>> src/mxfp4_block_dequantizer_macros.svh
// Assertion macros used by the checker file.
`ifndef MXFP4_BLOCK_DEQUANTIZER_MACROS_SVH
`define MXFP4_BLOCK_DEQUANTIZER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MXD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MXD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mxd_pkg.sv
// ----------------------------------------------------------------------------
// MXFP4 dequantizer package
// Payload types and the nibble-to-fp16 decode function.
// ----------------------------------------------------------------------------
`default_nettype none

package mxd_pkg;

    localparam logic [15:0] FP16_INF  = 16'h7C00;
    localparam logic [15:0] FP16_SIGN = 16'h8000;

    typedef struct packed {
        logic [7:0] weight_byte;
        logic [7:0] scale_exponent;
    } mxd_in_t;

    typedef struct packed {
        logic [15:0] low_half;
        logic [15:0] high_half;
    } mxd_out_t;

    // Decode one E2M1 code scaled by 2^(e-127) into fp16 bits.
    function automatic logic [15:0] decode_nibble(input logic [3:0] code,
                                                  input logic [7:0] e);
        logic [3:0]       m;
        logic [1:0]       p;
        logic signed [9:0] s;
        logic signed [9:0] ex;
        logic signed [9:0] sh;
        logic [15:0]      sign;
        logic [9:0]       frac;
        logic [3:0]       q;
        logic [3:0]       rem;
        logic [3:0]       half;
        logic [2:0]       k;
        logic [15:0]      res;
        sign = code[3] ? FP16_SIGN : 16'h0000;
        case (code[2:1])
            2'd0:    m = {3'b000, code[0]};
            2'd1:    m = {2'b00, 1'b1, code[0]};
            2'd2:    m = {1'b0, 1'b1, code[0], 1'b0};
            default: m = {1'b1, code[0], 2'b00};
        endcase
        if (m[3])      p = 2'd3;
        else if (m[2]) p = 2'd2;
        else if (m[1]) p = 2'd1;
        else           p = 2'd0;
        s  = $signed({2'b00, e}) - 10'sd128;
        ex = s + $signed({8'd0, p});
        sh = s + 10'sd24;
        frac = 10'd0;
        k = 3'd0;
        q = 4'd0;
        rem = 4'd0;
        half = 4'd0;
        if (m == 4'd0) begin
            res = 16'h0000;
        end else if (ex > 10'sd15) begin
            res = sign | FP16_INF;
        end else if (ex >= -10'sd14) begin
            frac = 10'({m, 10'd0} >> p);
            res = sign | {1'b0, 5'(ex + 10'sd15), frac};
        end else if (sh >= 10'sd0) begin
            res = sign | (16'(m) << sh[3:0]);
        end else if (sh <= -10'sd5) begin
            res = sign;
        end else begin
            k = 3'(-sh);
            q = m >> k;
            rem = m & ((4'd1 << k) - 4'd1);
            half = 4'd1 << (k - 3'd1);
            if (rem > half || (rem == half && q[0]))
                q = q + 4'd1;
            res = sign | 16'(q);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/mxd_decode.sv
// ----------------------------------------------------------------------------
// MXFP4 byte decoder
// Combinational decode of both nibbles of one weight byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mxd_decode (
    input  wire mxd_pkg::mxd_in_t  din,
    output var  mxd_pkg::mxd_out_t dout
);
    import mxd_pkg::*;

    always_comb
    begin
        dout.low_half  = decode_nibble(din.weight_byte[3:0], din.scale_exponent);
        dout.high_half = decode_nibble(din.weight_byte[7:4], din.scale_exponent);
    end
endmodule

`default_nettype wire

>>> src/mxfp4_block_dequantizer.sv
// ----------------------------------------------------------------------------
// MXFP4 block dequantizer
// Turns a byte of two E2M1 codes and an E8M0 exponent into two fp16 values.
// ----------------------------------------------------------------------------
//   channel   payload                         handshake
//   in        weight_byte, scale_exponent     in_valid / in_stall
//   out       low_half, high_half             out_valid / out_stall
//
// One transaction per cycle is sustained while out_stall is low; an accepted
// input is held in the input register, then its result in the output register.
// The input register feeds the decode logic, which feeds the output register;
// a stage advances whenever the stage after it is empty or moving.
// Reset clears both valid flags; payload registers are not reset.
// A stall holds a full output stage; in_stall rises only when both are full.
`default_nettype none

module mxfp4_block_dequantizer (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire  mxd_pkg::mxd_in_t  in_data,
    output logic                    out_valid,
    input  wire                     out_stall,
    output var   mxd_pkg::mxd_out_t out_data
);
    import mxd_pkg::*;

    mxd_in_t  in_reg;
    logic     in_vld_reg;
    mxd_out_t out_reg;
    logic     out_vld_reg;
    mxd_out_t dec;
    logic     out_take;
    logic     in_take;

    mxd_decode u_decode (
        .din  (in_reg),
        .dout (dec)
    );

    // The output stage may load when it is empty or being drained.
    assign out_take = !out_vld_reg || !out_stall;
    // The input stage may load when it is empty or moving forward.
    assign in_take  = !in_vld_reg || out_take;
    assign in_stall = !in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= in_valid;
            if (out_take)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
            in_reg <= in_data;
        if (out_take && in_vld_reg)
            out_reg <= dec;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
endmodule

`default_nettype wire

>>> src/mxd_checker.sv
// ----------------------------------------------------------------------------
// MXFP4 dequantizer port checker
// Port-level checks over time, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mxfp4_block_dequantizer_macros.svh"

module mxd_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    in_valid,
    input wire                    in_stall,
    input wire                    out_valid,
    input wire                    out_stall,
    input wire mxd_pkg::mxd_out_t out_data
);
    `MXD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `MXD_ASSERT_IMPL(a_no_stall_empty, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")
    `MXD_ASSERT_NEXT(a_in_to_out, clk, rst_n, in_valid && !in_stall && !out_valid, ##1 out_valid, "accepted item never reached output")
endmodule

bind mxfp4_block_dequantizer mxd_checker u_mxd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

>>> test/tb_mxfp4_block_dequantizer.sv
// ----------------------------------------------------------------------------
// MXFP4 block dequantizer testbench
// Drives weight bytes and block exponents through the valid/stall channels,
// predicts both fp16 halves with an independent integer decoder, and checks
// every output transaction in order under several idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mxfp4_block_dequantizer;

    import mxd_pkg::*;

    // Directed rows carry an expected result only where it is obvious;
    // a row with known = 0 is checked against the predictor instead.
    typedef struct {
        logic [7:0]  wbyte;
        logic [7:0]  sexp;
        bit          known;
        logic [15:0] lo;
        logic [15:0] hi;
    } vector_row_t;

    localparam int NUM_ROWS   = 16;
    localparam int NUM_RANDOM = 1600;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    mxd_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    mxd_out_t out_data;

    mxd_out_t    expected_halves[$];
    int          mismatch_count;
    int          idle_pct;
    int          stall_pct;
    vector_row_t vector_table[NUM_ROWS];

    mxfp4_block_dequantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: the slowest correct run is well under this.
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Twice the E2M1 magnitude, then scaled by 2^(e-128) and rounded into
    // fp16 with ties to even. All arithmetic is exact integer work.
    function automatic logic [15:0] fp16_of_code(input logic [3:0] code,
                                                 input logic [7:0] e);
        int          mag;
        int          msb;
        int          scale;
        int          unbiased;
        int          shift;
        int          quot;
        int          remainder;
        int          halfway;
        logic [15:0] sign_bit;
        sign_bit = code[3] ? 16'h8000 : 16'h0000;
        if (code[2:1] == 2'd0)
            mag = code[0];
        else
            mag = (2 + code[0]) << (code[2:1] - 1);
        if (mag == 0)
            return 16'h0000;
        msb = 0;
        while (msb < 3 && (mag >> (msb + 1)) != 0)
            msb++;
        scale = int'(e) - 128;
        unbiased = msb + scale;
        if (unbiased > 15)
            return sign_bit | 16'h7C00;
        if (unbiased >= -14)
            return sign_bit | 16'((unbiased + 15) << 10)
                            | 16'((mag << (10 - msb)) & 'h3FF);
        // Subnormal range, counted in units of 2^-24.
        shift = scale + 24;
        if (shift >= 0)
            return sign_bit | 16'(mag << shift);
        if (-shift >= 5)
            return sign_bit;
        quot = mag >> (-shift);
        remainder = mag & ((1 << (-shift)) - 1);
        halfway = 1 << (-shift - 1);
        if (remainder > halfway || (remainder == halfway && quot[0]))
            quot++;
        return sign_bit | 16'(quot);
    endfunction

    function automatic mxd_out_t dequantize_byte(input mxd_in_t item);
        mxd_out_t r;
        r.low_half  = fp16_of_code(item.weight_byte[3:0], item.scale_exponent);
        r.high_half = fp16_of_code(item.weight_byte[7:4], item.scale_exponent);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sends one transaction; the expectation is queued when it is accepted.
    // The caller's valid stays high between back-to-back items.
    task automatic send_byte(input mxd_in_t item, input mxd_out_t want);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_halves.push_back(want);
    endtask

    // Output side: random stall, and a check of every accepted transaction.
    always @(posedge clk)
    begin
        mxd_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_halves.size() == 0)
                begin
                    $display("unexpected output transaction at %0t", $realtime);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_halves.pop_front();
                    if (out_data.low_half !== want.low_half)
                        report_mismatch("low_half", out_data.low_half, want.low_half);
                    if (out_data.high_half !== want.high_half)
                        report_mismatch("high_half", out_data.high_half, want.high_half);
                end
            end
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        mxd_in_t  item;
        mxd_out_t want;
        int       waited;
        int       phase;
        // Extremes: zero codes, largest code at the unit scale, overflow at
        // the top exponent, underflow at the bottom, and the rounding edges.
        vector_table = '{
            '{8'h00, 8'd128, 1, 16'h0000, 16'h0000},  // both zeros
            '{8'h88, 8'd128, 1, 16'h0000, 16'h0000},  // negative zero codes
            '{8'h80, 8'd0,   1, 16'h0000, 16'h0000},
            '{8'h7F, 8'd128, 1, 16'hCA00, 16'h4A00},  // -12 and 12
            '{8'hF7, 8'd255, 1, 16'h7C00, 16'hFC00},  // signed infinity
            '{8'h19, 8'd128, 1, 16'hBC00, 16'h3C00},  // -1 and +1
            '{8'hFF, 8'd0,   1, 16'h8000, 16'h8000},  // negative to -0
            '{8'h77, 8'd0,   1, 16'h0000, 16'h0000},
            '{8'h12, 8'd104, 0, 16'h0, 16'h0},        // smallest subnormal
            '{8'h31, 8'd103, 0, 16'h0, 16'h0},        // ties to even
            '{8'h53, 8'd101, 0, 16'h0, 16'h0},
            '{8'h76, 8'd100, 0, 16'h0, 16'h0},
            '{8'hE4, 8'd114, 0, 16'h0, 16'h0},        // normal boundary
            '{8'h65, 8'd143, 0, 16'h0, 16'h0},        // near overflow
            '{8'hA9, 8'd144, 0, 16'h0, 16'h0},
            '{8'hCB, 8'd255, 0, 16'h0, 16'h0}
        };
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vector_table[i])
        begin
            item.weight_byte    = vector_table[i].wbyte;
            item.scale_exponent = vector_table[i].sexp;
            if (vector_table[i].known)
            begin
                want.low_half  = vector_table[i].lo;
                want.high_half = vector_table[i].hi;
            end
            else
                want = dequantize_byte(item);
            send_byte(item, want);
        end

        // Random phases: none, sender idle, receiver stall, both.
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            phase = n / (NUM_RANDOM / 4);
            idle_pct  = (phase == 1) ? 76 : (phase == 3) ? 29 : 0;
            stall_pct = (phase == 2) ? 76 : (phase == 3) ? 29 : 0;
            // Stretches without idling inside the idle phases.
            if ((n % 100) >= 85)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            item.weight_byte = 8'($urandom);
            // Most exponents sit where the interesting ranges are.
            if ($urandom_range(3) == 0)
                item.scale_exponent = 8'($urandom);
            else
                item.scale_exponent = 8'($urandom_range(150, 96));
            send_byte(item, dequantize_byte(item));
        end
        in_valid <= 1'b0;

        waited = 0;
        while (expected_halves.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_halves.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> mxfp4_block_dequantizer.f
+incdir+src
src/mxd_pkg.sv
src/mxd_decode.sv
src/mxfp4_block_dequantizer.sv
src/mxd_checker.sv
test/tb_mxfp4_block_dequantizer.sv
